FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent check wrappers, compiled out when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle check");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle check");

`else

`define ASSERT_IMPL(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

FILE: rtl/dms_pkg.sv
// ----------------------------------------------------------------------------
// dms_pkg
// Widths, constants and register codes of the dropout mask scaler.
// ----------------------------------------------------------------------------
package dms_pkg;

   localparam int VALUE_W     = 32;
   localparam int SCALE_W     = 24;
   localparam int THRESH_W    = 24;
   localparam int INDEX_W     = 12;
   localparam int RNG_W       = 32;
   localparam int FRAC_W      = 16;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_INDEX_W = 2;

   localparam int PROD_W = VALUE_W + SCALE_W + 1;
   localparam int SUM_W  = PROD_W + 1;
   localparam int QUOT_W = SUM_W - FRAC_W;

   localparam int DMS_MAX_ELEMENTS = 4096;

   localparam logic [RNG_W-1:0]    LCG_MUL      = 32'd1664525;
   localparam logic [RNG_W-1:0]    LCG_ADD      = 32'd1013904223;
   localparam logic [RNG_W-1:0]    SEED_RESET   = 32'h00C0_FFEE;
   localparam logic [THRESH_W-1:0] THRESH_RESET = 24'h80_0000;
   localparam logic [SCALE_W-1:0]  SCALE_RESET  = 24'h02_0000;
   localparam logic                TRAIN_RESET  = 1'b1;

   localparam logic [SUM_W-1:0]   ROUND_HALF = SUM_W'(1) << (FRAC_W - 1);
   localparam logic [VALUE_W-1:0] VALUE_MAX  = {1'b0, {(VALUE_W-1){1'b1}}};
   localparam logic [VALUE_W-1:0] VALUE_MIN  = {1'b1, {(VALUE_W-1){1'b0}}};

   localparam logic [CSR_INDEX_W-1:0] CSR_DROP_THRESHOLD = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEEP_SCALE     = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TRAIN_MODE     = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_RNG_SEED       = 2'd3;

   localparam logic MODE_FWD = 1'b0;
   localparam logic MODE_BWD = 1'b1;

endpackage

FILE: rtl/dms_req_if.sv
// ----------------------------------------------------------------------------
// dms_req_if
// Element channel into the dropout mask scaler.
// ----------------------------------------------------------------------------
interface dms_req_if import dms_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic                      mode;
   logic signed [VALUE_W-1:0] in_value;
   logic [INDEX_W-1:0]        elem_index;

   modport source (output valid, output mode, output in_value, output elem_index,
                   input ready);
   modport sink   (input valid, input mode, input in_value, input elem_index,
                   output ready);
endinterface

FILE: rtl/dms_rsp_if.sv
// ----------------------------------------------------------------------------
// dms_rsp_if
// Result channel out of the dropout mask scaler.
// ----------------------------------------------------------------------------
interface dms_rsp_if import dms_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [VALUE_W-1:0] out_value;
   logic                      kept;

   modport source (output valid, output out_value, output kept, input ready);
   modport sink   (input valid, input out_value, input kept, output ready);
endinterface

FILE: rtl/dropout_mask_scaler_unit.sv
// ----------------------------------------------------------------------------
// dropout_mask_scaler_unit
// Inverted dropout on Q16.16 elements with an LCG keep mask and a stored
// per-index mask for the backward pass.
// ----------------------------------------------------------------------------
//  channel  direction  handshake            payload
//  req      in         req.valid/req.ready  mode, in_value, elem_index
//  rsp      out        rsp.valid/rsp.ready  out_value, kept
//  csr      in         csr_we               csr_index, csr_wdata
//
//  One element per cycle while no result stalls; each result passes stages A, B and the result register.
//  The generator step sets the accept-side path; the keep compare, the mask
//  bypass and the 32x25 scale multiply sit between stages A and B.
//  A stalled result holds the whole pipe; req.ready drops with it.
//  Synchronous reset clears the pipe and loads the register reset values.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dropout_mask_scaler_unit import dms_pkg::*; #(
   parameter int MAX_ELEMENTS = DMS_MAX_ELEMENTS
) (
   input  logic                   clock,
   input  logic                   reset,
   dms_req_if.sink                req,
   dms_rsp_if.source              rsp,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int ADDR_W = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
   localparam int IDX_W  = (ADDR_W > INDEX_W) ? ADDR_W : INDEX_W;

   logic [THRESH_W-1:0] thresh_ff, thresh_in;
   logic [SCALE_W-1:0]  scale_ff, scale_in;
   logic                train_ff, train_in;
   logic [RNG_W-1:0]    rng_ff, rng_in;

   logic                      a_valid_ff, a_pass_ff, a_mode_ff, a_in_range_ff;
   logic signed [VALUE_W-1:0] a_value_ff;
   logic [ADDR_W-1:0]         a_addr_ff;
   logic [THRESH_W-1:0]       a_rnd_ff;

   logic                      b_valid_ff, b_pass_ff, b_keep_ff, b_wr_ff;
   logic signed [VALUE_W-1:0] b_value_ff;
   logic [ADDR_W-1:0]         b_addr_ff;
   logic signed [PROD_W-1:0]  b_prod_ff;

   logic                      rsp_valid_ff, rsp_kept_ff;
   logic [VALUE_W-1:0]        rsp_value_ff, rsp_value_in;

   logic                      pipe_en, accept, active, fwd_step, seed_wr;
   logic [RNG_W-1:0]          rng_prod, rng_step;
   logic [IDX_W-1:0]          req_idx_wide;
   logic [ADDR_W-1:0]         req_addr;
   logic                      req_in_range;
   logic                      mem_rd_bit, stored_bit, keep_a;
   logic                      wr_en, wr_pending;
   logic signed [PROD_W-1:0]  mult_a, mult_b, prod_in;
   logic [SUM_W-1:0]          round_sum;
   logic [QUOT_W-1:0]         quot;
   logic [VALUE_W-1:0]        sat_value;
   logic                      no_ovf;

   assign pipe_en   = !rsp_valid_ff || rsp.ready;
   assign req.ready = pipe_en;
   assign accept    = req.valid && pipe_en;
   assign active    = train_ff && (thresh_ff != '0);
   assign fwd_step  = accept && active && (req.mode == MODE_FWD);
   assign seed_wr   = csr_we && (csr_index == CSR_RNG_SEED);

   assign rng_prod = rng_ff * LCG_MUL;
   assign rng_step = rng_prod + LCG_ADD;

   always_comb begin
      thresh_in = thresh_ff;
      scale_in  = scale_ff;
      train_in  = train_ff;
      rng_in    = fwd_step ? rng_step : rng_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_DROP_THRESHOLD: thresh_in = csr_wdata[THRESH_W-1:0];
            CSR_KEEP_SCALE:     scale_in  = csr_wdata[SCALE_W-1:0];
            CSR_TRAIN_MODE:     train_in  = csr_wdata[0];
            CSR_RNG_SEED:       rng_in    = csr_wdata[RNG_W-1:0];
            default:            thresh_in = thresh_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= THRESH_RESET;
         scale_ff  <= SCALE_RESET;
         train_ff  <= TRAIN_RESET;
         rng_ff    <= SEED_RESET;
      end else begin
         thresh_ff <= thresh_in;
         scale_ff  <= scale_in;
         train_ff  <= train_in;
         rng_ff    <= rng_in;
      end
   end

   assign req_idx_wide = IDX_W'(req.elem_index);
   assign req_addr     = req_idx_wide[ADDR_W-1:0];
   assign req_in_range = 32'(req.elem_index) < 32'(MAX_ELEMENTS);

   // stage A: registered element, generator draw and mask read
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         a_valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         a_pass_ff     <= !active;
         a_mode_ff     <= req.mode;
         a_in_range_ff <= req_in_range;
         a_value_ff    <= req.in_value;
         a_addr_ff     <= req_addr;
         a_rnd_ff      <= rng_step[THRESH_W-1:0];
      end
   end

   dms_mask_store #(
      .MAX_ELEMENTS (MAX_ELEMENTS)
   ) u_mask_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (a_addr_ff),
      .wr_bit  (keep_a),
      .rd_en   (pipe_en),
      .rd_addr (req_addr),
      .rd_bit  (mem_rd_bit)
   );

   // bypass the write landing in the same edge as this read
   assign stored_bit = (b_wr_ff && (b_addr_ff == a_addr_ff)) ? b_keep_ff : mem_rd_bit;

   always_comb begin
      if (a_pass_ff) begin
         keep_a = 1'b1;
      end else if (a_mode_ff == MODE_FWD) begin
         keep_a = a_rnd_ff >= thresh_ff;
      end else begin
         keep_a = a_in_range_ff && stored_bit;
      end
   end

   assign wr_pending = !a_pass_ff && (a_mode_ff == MODE_FWD) && a_in_range_ff;
   assign wr_en      = pipe_en && a_valid_ff && wr_pending;

   assign mult_a  = PROD_W'(a_value_ff);
   assign mult_b  = PROD_W'($signed({1'b0, scale_ff}));
   assign prod_in = mult_a * mult_b;

   // stage B: keep decision and raw product
   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
         b_wr_ff    <= 1'b0;
      end else if (pipe_en) begin
         b_valid_ff <= a_valid_ff;
         b_wr_ff    <= a_valid_ff && wr_pending;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         b_pass_ff  <= a_pass_ff;
         b_keep_ff  <= keep_a;
         b_value_ff <= a_value_ff;
         b_addr_ff  <= a_addr_ff;
         b_prod_ff  <= prod_in;
      end
   end

   // round half up, floor to Q16.16, saturate
   assign round_sum = SUM_W'(b_prod_ff) + ROUND_HALF;
   assign quot      = round_sum[SUM_W-1:FRAC_W];
   assign no_ovf    = (quot[QUOT_W-1:VALUE_W-1] == '0) ||
                      (quot[QUOT_W-1:VALUE_W-1] == '1);
   assign sat_value = no_ovf ? quot[VALUE_W-1:0] : (quot[QUOT_W-1] ? VALUE_MIN : VALUE_MAX);

   always_comb begin
      if (b_pass_ff) begin
         rsp_value_in = b_value_ff;
      end else if (b_keep_ff) begin
         rsp_value_in = sat_value;
      end else begin
         rsp_value_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         rsp_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         rsp_value_ff <= rsp_value_in;
         rsp_kept_ff  <= b_keep_ff;
      end
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.out_value = rsp_value_ff;
   assign rsp.kept      = rsp_kept_ff;

   `ASSERT_IMPL(a_drop_is_zero, clock, reset, rsp_valid_ff && !rsp_kept_ff, rsp_value_ff == '0)
   `ASSERT_NEXT(a_rng_hold, clock, reset, !fwd_step && !seed_wr, rng_ff == $past(rng_ff))
   `ASSERT_IMPL(a_pass_no_write, clock, reset, a_valid_ff && a_pass_ff, !wr_en)
   `ASSERT_NEXT(a_stall_hold, clock, reset, !pipe_en, b_valid_ff == $past(b_valid_ff))

endmodule

FILE: rtl/dms_mask_store.sv
// ----------------------------------------------------------------------------
// dms_mask_store
// One keep bit per element index; one write and one registered read a cycle.
// ----------------------------------------------------------------------------
module dms_mask_store import dms_pkg::*; #(
   parameter int  MAX_ELEMENTS = DMS_MAX_ELEMENTS,
   localparam int ADDR_W = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic              wr_bit,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic              rd_bit
);

   logic mask_mem [MAX_ELEMENTS];
   logic rd_bit_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mask_mem[wr_addr] <= wr_bit;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_bit_ff <= mask_mem[rd_addr];
      end
   end

   assign rd_bit = rd_bit_ff;

endmodule

FILE: test/dropout_mask_scaler_unit_compare.sv
// ----------------------------------------------------------------------------
// dropout_mask_scaler_unit_compare
// Watches the element, result and register ports of the dropout mask scaler.
// Keeps its own copy of the settings, the generator and the keep mask,
// predicts every result word and compares it field by field, in order.
// ----------------------------------------------------------------------------
module dropout_mask_scaler_unit_compare import dms_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   dms_req_if                     req,
   dms_rsp_if                     rsp,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output int unsigned            fail_count,
   output int unsigned            outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic                      kept;
   } element_type;

   logic [THRESH_W-1:0] threshold;
   logic [SCALE_W-1:0]  scale;
   logic                training;
   logic [RNG_W-1:0]    lcg;
   logic                keep_bits [DMS_MAX_ELEMENTS];
   element_type         expected_q [$];
   int unsigned         fails = 0;

   function automatic logic [VALUE_W-1:0] scaled(logic signed [VALUE_W-1:0] x);
      longint prod;
      longint quot;
      prod = longint'(x) * longint'({1'b0, scale}) + (longint'(1) <<< (FRAC_W - 1));
      quot = prod >>> FRAC_W;
      if (quot > longint'(32'h7FFF_FFFF)) return VALUE_MAX;
      if (quot < -longint'(32'h8000_0000)) return VALUE_MIN;
      return quot[VALUE_W-1:0];
   endfunction

   task automatic report(string msg);
      if (fails < 200) begin
         $display("%0t ns mismatch: %s", $time, msg);
      end
      fails++;
   endtask

   task automatic predict_word(logic m, logic signed [VALUE_W-1:0] x,
                               logic [INDEX_W-1:0] idx);
      element_type e;
      logic        keep;
      if (!training || threshold == '0) begin
         e.value = x;
         e.kept  = 1'b1;
      end else begin
         if (m == MODE_FWD) begin
            lcg            = lcg * LCG_MUL + LCG_ADD;
            keep           = lcg[THRESH_W-1:0] >= threshold;
            keep_bits[idx] = keep;
         end else begin
            keep = keep_bits[idx];
         end
         e.value = keep ? scaled(x) : '0;
         e.kept  = keep;
      end
      expected_q.push_back(e);
   endtask

   always @(posedge clock) begin : watch
      element_type want;
      if (reset) begin
         threshold = THRESH_RESET;
         scale     = SCALE_RESET;
         training  = TRAIN_RESET;
         lcg       = SEED_RESET;
         expected_q.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_DROP_THRESHOLD: threshold = csr_wdata[THRESH_W-1:0];
               CSR_KEEP_SCALE:     scale     = csr_wdata[SCALE_W-1:0];
               CSR_TRAIN_MODE:     training  = csr_wdata[0];
               CSR_RNG_SEED:       lcg       = csr_wdata[RNG_W-1:0];
               default: ;
            endcase
         end
         if (rsp.valid && rsp.ready) begin
            if (expected_q.size() == 0) begin
               report($sformatf("unexpected word value %h kept %b",
                                rsp.out_value, rsp.kept));
            end else begin
               want = expected_q.pop_front();
               if (rsp.out_value !== want.value) begin
                  report($sformatf("out_value expected %h got %h",
                                   want.value, rsp.out_value));
               end
               if (rsp.kept !== want.kept) begin
                  report($sformatf("kept expected %b got %b", want.kept, rsp.kept));
               end
            end
         end
         if (req.valid && req.ready) begin
            predict_word(req.mode, req.in_value, req.elem_index);
         end
      end
      fail_count  <= fails;
      outstanding <= expected_q.size();
   end

endmodule

FILE: test/dropout_mask_scaler_unit_test.sv
// ----------------------------------------------------------------------------
// dropout_mask_scaler_unit_test
// Drives forward and backward element streams through the dropout mask
// scaler under a series of register settings, with random gaps on both
// channels, and reports the verdict of the result comparison.
// ----------------------------------------------------------------------------
module dropout_mask_scaler_unit_test;
   timeunit 1ns;
   timeprecision 1ps;
   import dms_pkg::*;

   localparam int unsigned WORD_TARGET = 1650;
   localparam int unsigned IDLE_LIMIT  = 4000;

   logic                   clock;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;
   int unsigned            fail_count;
   int unsigned            outstanding;

   dms_req_if req ();
   dms_rsp_if rsp ();

   dropout_mask_scaler_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .rsp       (rsp),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   dropout_mask_scaler_unit_compare i_compare (
      .clock       (clock),
      .reset       (reset),
      .req         (req),
      .rsp         (rsp),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   logic [THRESH_W-1:0] cur_threshold = THRESH_RESET;
   logic                cur_train     = TRAIN_RESET;
   bit                  written [DMS_MAX_ELEMENTS];
   logic [INDEX_W-1:0]  written_q [$];
   bit                  quiet = 1'b0;
   int unsigned         fwd_words = 0;
   int unsigned         bwd_words = 0;
   int unsigned         pass_words = 0;
   int unsigned         settings = 0;
   int unsigned         idle_cycles;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (quiet || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic bit dropout_on();
      return cur_train && cur_threshold != '0;
   endfunction

   function automatic logic signed [VALUE_W-1:0] rand_value();
      int unsigned               r;
      logic signed [VALUE_W-1:0] mag;
      r = $urandom_range(0, 9);
      if (r < 5) return $urandom;
      if (r < 8) begin
         mag = $urandom_range(0, 32'h3FFFF);
         return $urandom_range(0, 1) ? -mag : mag;
      end
      case ($urandom_range(0, 3))
         0:       return VALUE_MAX;
         1:       return VALUE_MIN;
         2:       return '0;
         default: return '1;
      endcase
   endfunction

   task automatic send_word(logic m, logic signed [VALUE_W-1:0] x,
                            logic [INDEX_W-1:0] idx);
      int unsigned gap;
      if (dropout_on() && m == MODE_FWD && !written[idx]) begin
         written[idx] = 1'b1;
         written_q.push_back(idx);
      end
      if (!dropout_on()) pass_words++;
      if (m == MODE_FWD) fwd_words++;
      else bwd_words++;
      req.valid      <= 1'b1;
      req.mode       <= m;
      req.in_value   <= x;
      req.elem_index <= idx;
      do @(posedge clock); while (!req.ready);
      gap = pick_gap();
      if (gap != 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // send a gradient to a written entry (any without dropout), else forward
   task automatic send_grad(logic signed [VALUE_W-1:0] x, logic [INDEX_W-1:0] idx);
      if (!dropout_on() || written[idx]) begin
         send_word(MODE_BWD, x, idx);
      end else if (written_q.size() != 0) begin
         send_word(MODE_BWD, x, written_q[$urandom_range(0, written_q.size() - 1)]);
      end else begin
         send_word(MODE_FWD, x, idx);
      end
   endtask

   task automatic settle();
      req.valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   task automatic apply_setting(logic [THRESH_W-1:0] thr, logic [SCALE_W-1:0] scl,
                                logic train, bit reseed, logic [RNG_W-1:0] seed);
      settle();
      write_reg(CSR_DROP_THRESHOLD, CSR_DATA_W'(thr));
      write_reg(CSR_KEEP_SCALE, CSR_DATA_W'(scl));
      write_reg(CSR_TRAIN_MODE, CSR_DATA_W'(train));
      if (reseed) write_reg(CSR_RNG_SEED, seed);
      csr_we        <= 1'b0;
      cur_threshold  = thr;
      cur_train      = train;
      settings++;
   endtask

   task automatic random_setting();
      logic [THRESH_W-1:0] thr;
      logic [SCALE_W-1:0]  scl;
      logic [RNG_W-1:0]    seed;
      case ($urandom_range(0, 9))
         0:       thr = '0;
         1:       thr = '1;
         2:       thr = 24'd1;
         3:       thr = THRESH_RESET;
         default: thr = THRESH_W'($urandom_range(0, 24'hFF_FFFF));
      endcase
      case ($urandom_range(0, 7))
         0:       scl = '0;
         1:       scl = '1;
         2:       scl = 24'h01_0000;
         3, 4:    scl = SCALE_W'($urandom_range(0, 24'h03_0000));
         default: scl = SCALE_W'($urandom_range(0, 24'hFF_FFFF));
      endcase
      case ($urandom_range(0, 3))
         0:       seed = '0;
         1:       seed = '1;
         default: seed = $urandom;
      endcase
      apply_setting(thr, scl, $urandom_range(0, 6) != 0,
                    settings < 6 || $urandom_range(0, 1), seed);
      quiet = $urandom_range(0, 5) == 0;
   endtask

   task automatic run_pass();
      int unsigned        len;
      logic [INDEX_W-1:0] base;
      logic [INDEX_W-1:0] idx;
      bit                 flip;
      len  = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 80) : $urandom_range(1, 24);
      base = INDEX_W'($urandom);
      flip = 1'($urandom_range(0, 1));
      for (int unsigned k = 0; k < len; k++) begin
         send_word(MODE_FWD, rand_value(), base + INDEX_W'(k));
      end
      if ($urandom_range(0, 4) != 0) begin
         for (int unsigned k = 0; k < len; k++) begin
            idx = flip ? base + INDEX_W'(len - 1 - k) : base + INDEX_W'(k);
            send_grad(rand_value(), idx);
         end
      end
   endtask

   task automatic run_noise();
      int unsigned n;
      n = $urandom_range(1, 8);
      for (int unsigned k = 0; k < n; k++) begin
         if ($urandom_range(0, 1)) send_word(MODE_FWD, $urandom, INDEX_W'($urandom));
         else send_grad($urandom, INDEX_W'($urandom));
      end
   endtask

   initial begin
      rsp.ready <= 1'b1;
      forever begin : sink_side
         int unsigned gap;
         repeat ($urandom_range(1, 20)) @(posedge clock);
         gap = pick_gap();
         if (gap != 0) begin
            rsp.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   initial begin
      reset          <= 1'b1;
      req.valid      <= 1'b0;
      req.mode       <= MODE_FWD;
      req.in_value   <= '0;
      req.elem_index <= '0;
      csr_we         <= 1'b0;
      csr_index      <= CSR_DROP_THRESHOLD;
      csr_wdata      <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      send_word(MODE_FWD, VALUE_MAX, 12'd0);
      send_word(MODE_FWD, VALUE_MIN, 12'd4095);
      send_word(MODE_FWD, 32'sd0, 12'd1);
      send_word(MODE_FWD, -32'sd1, 12'd2);
      send_word(MODE_FWD, 32'sd1, 12'd3);
      send_word(MODE_FWD, 32'sh0000_8000, 12'd4);
      send_word(MODE_FWD, -32'sh0000_8000, 12'd5);
      send_word(MODE_FWD, 32'sh3FFF_FFFF, 12'd6);
      send_grad(VALUE_MIN, 12'd0);
      send_grad(VALUE_MAX, 12'd4095);
      send_grad(-32'sd1, 12'd1);
      send_grad(32'sd1, 12'd2);
      send_grad(32'sh0000_8000, 12'd3);
      send_grad(-32'sh0000_8000, 12'd4);
      send_grad(32'sh4000_0000, 12'd5);
      send_grad(32'sh1234_5678, 12'd6);
      apply_setting(24'd1, '0, 1'b1, 1'b0, '0);
      send_word(MODE_FWD, 32'sh0001_0000, 12'd7);
      apply_setting(THRESH_RESET, 24'h01_8000, 1'b0, 1'b0, '0);
      send_word(MODE_BWD, 32'sh0BAD_0000, 12'd2000);
      send_word(MODE_FWD, VALUE_MIN, 12'd2001);
      apply_setting('0, SCALE_RESET, 1'b1, 1'b0, '0);
      send_word(MODE_BWD, -32'sd7, 12'd2002);
      send_word(MODE_FWD, VALUE_MAX, 12'd2003);
      apply_setting(24'd1, '1, 1'b1, 1'b1, '1);
      send_word(MODE_FWD, VALUE_MAX, 12'd8);
      send_word(MODE_FWD, VALUE_MIN, 12'd9);

      while (fwd_words + bwd_words < WORD_TARGET) begin
         random_setting();
         repeat ($urandom_range(2, 6)) begin
            if ($urandom_range(0, 9) < 8) run_pass();
            else run_noise();
         end
      end

      settle();
      repeat (8) @(posedge clock);
      $display("ran %0d words (%0d forward, %0d backward, %0d passed through)",
               fwd_words + bwd_words, fwd_words, bwd_words, pass_words);
      $display("over %0d register settings, %0d mask entries written",
               settings, written_q.size());
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

FILE: dropout_mask_scaler_unit.f
+incdir+rtl
rtl/dms_pkg.sv
rtl/dms_req_if.sv
rtl/dms_rsp_if.sv
rtl/dms_mask_store.sv
rtl/dropout_mask_scaler_unit.sv
test/dropout_mask_scaler_unit_compare.sv
test/dropout_mask_scaler_unit_test.sv
